### rtl/segment_intersection_test_macros.svh
// assertion macros shared by the segment intersection rtl
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef SEGMENT_INTERSECTION_TEST_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_MACROS_SVH
`ifndef SYNTHESIS
`define SIT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("segment intersection check failed");
`define SIT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("segment intersection invariant failed");
`else
`define SIT_ASSERT(label, clk, rst_n, prop)
`define SIT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### rtl/sit_pkg.sv
// shared constants and types for the segment intersection pipeline
// no dependencies
package sit_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int NUM_COORDS      = 8;
  localparam int NUM_TURNS       = 4;
  localparam int NUM_TERMS       = 4;
  localparam int OUT_TDATA_W     = 8;

  typedef enum logic [1:0] {
    TURN_COLLINEAR = 2'd0,
    TURN_CW        = 2'd1,
    TURN_CCW       = 2'd2
  } turn_e;

endpackage

### rtl/segment_intersection_test.sv
// Segment intersection test, streaming in and out.
// Input channel s_axis: one word carries two segments, eight signed coordinates
// of COORD_WIDTH bits each. Output channel m_axis: one word per input word with
// the intersects flag (1 when the closed segments share at least one point).
// The accepting edge loads the first of four register stages: differences and
// bounding boxes, cross product terms, orientation compare, and the final decision
// in the output register.
// Throughput: one word per cycle while m_axis_tready stays high; every stage holds
// one word and moves it whenever the stage after it is empty or moving.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver holds m_axis_tready low, the output word holds steady and the
// stages behind it fill up; s_axis_tready falls only once all four are full.
// Depends on sit_pkg, sit_diff, sit_mul, sit_dec and the assertion macro header.
`include "segment_intersection_test_macros.svh"
module segment_intersection_test #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // a_start_x, a_start_y, a_end_x, a_end_y, b_start_x, b_start_y, b_end_x, b_end_y
  input  logic [((sit_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready,
  // intersects, then zero fill
  output logic [sit_pkg::OUT_TDATA_W-1:0]           m_axis_tdata
);
  import sit_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic                                        diff_valid, diff_ready;
  logic [NUM_TURNS-1:0][NUM_TERMS-1:0][DW-1:0] diff;
  logic [NUM_TURNS-1:0]                        diff_box;
  logic                                        prod_valid, prod_ready;
  logic [NUM_TURNS-1:0][PW-1:0]                prod_lhs, prod_rhs;
  logic [NUM_TURNS-1:0]                        prod_box;
  logic                                        hit;

  sit_diff #(
    .CoordWidth(COORD_WIDTH)
  ) u_diff (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .coords_i(s_axis_tdata[NUM_COORDS*COORD_WIDTH-1:0]),
    .valid_o (diff_valid),
    .ready_i (diff_ready),
    .diff_o  (diff),
    .box_o   (diff_box)
  );

  sit_mul #(
    .CoordWidth(COORD_WIDTH)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(diff_valid),
    .ready_o(diff_ready),
    .diff_i (diff),
    .box_i  (diff_box),
    .valid_o(prod_valid),
    .ready_i(prod_ready),
    .lhs_o  (prod_lhs),
    .rhs_o  (prod_rhs),
    .box_o  (prod_box)
  );

  sit_dec #(
    .CoordWidth(COORD_WIDTH)
  ) u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(prod_valid),
    .ready_o(prod_ready),
    .lhs_i  (prod_lhs),
    .rhs_i  (prod_rhs),
    .box_i  (prod_box),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .hit_o  (hit)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, hit};

  // input back-pressure only ever comes from a stalled, full output
  `SIT_ASSERT(a_top_backpressure, clk_i, rst_ni,
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
  // nothing leaves an empty pipeline: no output right after reset release
  `SIT_ASSERT(a_top_empty_after_reset, clk_i, rst_ni,
    $rose(rst_ni) |-> !m_axis_tvalid)

endmodule

### rtl/sit_diff.sv
// stage 1: coordinate differences for the four cross products and bounding box tests
// depends on sit_pkg
module sit_diff #(
  parameter int CoordWidth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic [sit_pkg::NUM_COORDS*CoordWidth-1:0] coords_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic [sit_pkg::NUM_TURNS-1:0][sit_pkg::NUM_TERMS-1:0][CoordWidth:0] diff_o,
  output logic [sit_pkg::NUM_TURNS-1:0]            box_o
);
  import sit_pkg::*;

  localparam int DW = CoordWidth + 1;

  logic signed [CoordWidth-1:0] px [4];
  logic signed [CoordWidth-1:0] py [4];

  logic [NUM_TURNS-1:0][NUM_TERMS-1:0][DW-1:0] diff_d, diff_q;
  logic [NUM_TURNS-1:0]                        box_d, box_q;
  logic                                        valid_q;

  // point order: a start, a end, b start, b end
  for (genvar k = 0; k < 4; k++) begin : g_pts
    assign px[k] = $signed(coords_i[(2*k)*CoordWidth +: CoordWidth]);
    assign py[k] = $signed(coords_i[(2*k+1)*CoordWidth +: CoordWidth]);
  end

  // turn t uses (p, q, r); the box test asks whether r lies in the box of p and q
  for (genvar t = 0; t < NUM_TURNS; t++) begin : g_turn
    localparam int P = (t < 2) ? 0 : 2;
    localparam int Q = P + 1;
    localparam int R = (t == 0) ? 2 : (t == 1) ? 3 : (t == 2) ? 0 : 1;

    assign diff_d[t][0] = $signed({py[Q][CoordWidth-1], py[Q]})
                        - $signed({py[P][CoordWidth-1], py[P]});
    assign diff_d[t][1] = $signed({px[R][CoordWidth-1], px[R]})
                        - $signed({px[Q][CoordWidth-1], px[Q]});
    assign diff_d[t][2] = $signed({px[Q][CoordWidth-1], px[Q]})
                        - $signed({px[P][CoordWidth-1], px[P]});
    assign diff_d[t][3] = $signed({py[R][CoordWidth-1], py[R]})
                        - $signed({py[Q][CoordWidth-1], py[Q]});

    assign box_d[t] = ((px[R] >= px[P] && px[R] <= px[Q]) ||
                       (px[R] >= px[Q] && px[R] <= px[P])) &&
                      ((py[R] >= py[P] && py[R] <= py[Q]) ||
                       (py[R] >= py[Q] && py[R] <= py[P]));
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      diff_q <= diff_d;
      box_q  <= box_d;
    end
  end

  assign valid_o = valid_q;
  assign diff_o  = diff_q;
  assign box_o   = box_q;

endmodule

### rtl/sit_mul.sv
// stage 2: the eight exact cross product terms, one multiplier each
// depends on sit_pkg and the assertion macro header
`include "segment_intersection_test_macros.svh"
module sit_mul #(
  parameter int CoordWidth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic [sit_pkg::NUM_TURNS-1:0][sit_pkg::NUM_TERMS-1:0][CoordWidth:0] diff_i,
  input  logic [sit_pkg::NUM_TURNS-1:0]            box_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic [sit_pkg::NUM_TURNS-1:0][2*CoordWidth+1:0] lhs_o,
  output logic [sit_pkg::NUM_TURNS-1:0][2*CoordWidth+1:0] rhs_o,
  output logic [sit_pkg::NUM_TURNS-1:0]            box_o
);
  import sit_pkg::*;

  localparam int DW = CoordWidth + 1;
  localparam int PW = 2 * DW;

  logic [NUM_TURNS-1:0][PW-1:0] lhs_d, lhs_q;
  logic [NUM_TURNS-1:0][PW-1:0] rhs_d, rhs_q;
  logic [NUM_TURNS-1:0]         box_q;
  logic                         valid_q;

  for (genvar t = 0; t < NUM_TURNS; t++) begin : g_prod
    logic signed [DW-1:0] dqpy, drqx, dqpx, drqy;
    logic signed [PW-1:0] lhs_s, rhs_s;
    assign dqpy  = $signed(diff_i[t][0]);
    assign drqx  = $signed(diff_i[t][1]);
    assign dqpx  = $signed(diff_i[t][2]);
    assign drqy  = $signed(diff_i[t][3]);
    assign lhs_s = PW'(dqpy) * PW'(drqx);
    assign rhs_s = PW'(dqpx) * PW'(drqy);
    assign lhs_d[t] = lhs_s;
    assign rhs_d[t] = rhs_s;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
      box_q <= box_i;
    end
  end

  assign valid_o = valid_q;
  assign lhs_o   = lhs_q;
  assign rhs_o   = rhs_q;
  assign box_o   = box_q;

  // a held word must keep its products while the next stage is full
  `SIT_ASSERT(a_mul_hold, clk_i, rst_ni,
    (valid_q && !ready_i) |=> (valid_q && $stable(lhs_q) && $stable(rhs_q)))

endmodule

### rtl/sit_dec.sv
// stages 3 and 4: orientation from product compare, then the intersection decision
// depends on sit_pkg and the assertion macro header
`include "segment_intersection_test_macros.svh"
module sit_dec #(
  parameter int CoordWidth = 16
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     valid_i,
  output logic                                     ready_o,
  input  logic [sit_pkg::NUM_TURNS-1:0][2*CoordWidth+1:0] lhs_i,
  input  logic [sit_pkg::NUM_TURNS-1:0][2*CoordWidth+1:0] rhs_i,
  input  logic [sit_pkg::NUM_TURNS-1:0]            box_i,
  output logic                                     valid_o,
  input  logic                                     ready_i,
  output logic                                     hit_o
);
  import sit_pkg::*;

  turn_e                turn_d [NUM_TURNS];
  turn_e                turn_q [NUM_TURNS];
  logic [NUM_TURNS-1:0] box_q;
  logic                 turn_valid_q;
  logic                 turn_ready;
  logic                 hit_d, hit_q;
  logic                 out_valid_q;
  logic                 general_hit;
  logic [NUM_TURNS-1:0] edge_hit;

  for (genvar t = 0; t < NUM_TURNS; t++) begin : g_turn
    always_comb begin
      if (lhs_i[t] == rhs_i[t]) begin
        turn_d[t] = TURN_COLLINEAR;
      end else if ($signed(lhs_i[t]) > $signed(rhs_i[t])) begin
        turn_d[t] = TURN_CW;
      end else begin
        turn_d[t] = TURN_CCW;
      end
    end
    // collinear triple whose third point sits on the segment
    assign edge_hit[t] = (turn_q[t] == TURN_COLLINEAR) && box_q[t];
  end

  assign general_hit = (turn_q[0] != turn_q[1]) && (turn_q[2] != turn_q[3]);
  assign hit_d       = general_hit || (|edge_hit);

  assign turn_ready = !out_valid_q || ready_i;
  assign ready_o    = !turn_valid_q || turn_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turn_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (ready_o) begin
        turn_valid_q <= valid_i;
      end
      if (turn_ready) begin
        out_valid_q <= turn_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      turn_q <= turn_d;
      box_q  <= box_i;
    end
    if (turn_ready && turn_valid_q) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = out_valid_q;
  assign hit_o   = hit_q;

  // proper crossing always reports a hit
  `SIT_ASSERT(a_dec_cross, clk_i, rst_ni,
    (turn_valid_q && turn_ready && turn_q[0] != turn_q[1] && turn_q[2] != turn_q[3])
      |=> (out_valid_q && hit_q))
  // the start point of b on segment a always reports a hit
  `SIT_ASSERT(a_dec_touch, clk_i, rst_ni,
    (turn_valid_q && turn_ready && turn_q[0] == TURN_COLLINEAR && box_q[0])
      |=> (out_valid_q && hit_q))

endmodule

### tb/segment_intersection_checker.sv
// checker for the segment intersection block: watches both stream channels,
// predicts the intersects flag of every accepted word and compares in order
// depends on sit_pkg
`timescale 1ns / 1ps
module segment_intersection_checker #(
  parameter int COORD_WIDTH = sit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  s_tvalid_i,
  input  logic                                                  s_tready_i,
  input  logic [((sit_pkg::NUM_COORDS*COORD_WIDTH+7)/8)*8-1:0] s_tdata_i,
  input  logic                                                  m_tvalid_i,
  input  logic                                                  m_tready_i,
  input  logic [sit_pkg::OUT_TDATA_W-1:0]                      m_tdata_i,
  output int                                                    error_count_o,
  output int                                                    pending_o
);
  import sit_pkg::*;

  localparam int IN_W = ((NUM_COORDS*COORD_WIDTH+7)/8)*8;

  bit expected_hits [$];

  // exact turn of p->q->r; products compared, never subtracted
  function automatic turn_e orientation(input longint px, input longint py,
                                        input longint qx, input longint qy,
                                        input longint rx, input longint ry);
    longint lhs;
    longint rhs;
    lhs = (qy - py) * (rx - qx);
    rhs = (qx - px) * (ry - qy);
    if (lhs == rhs) return TURN_COLLINEAR;
    return (lhs > rhs) ? TURN_CW : TURN_CCW;
  endfunction

  // q inside the box spanned by p and r, borders included
  function automatic bit within_box(input longint px, input longint py,
                                    input longint qx, input longint qy,
                                    input longint rx, input longint ry);
    longint xmax;
    longint xmin;
    longint ymax;
    longint ymin;
    xmax = (px > rx) ? px : rx;
    xmin = (px < rx) ? px : rx;
    ymax = (py > ry) ? py : ry;
    ymin = (py < ry) ? py : ry;
    return qx <= xmax && qx >= xmin && qy <= ymax && qy >= ymin;
  endfunction

  function automatic bit segments_touch(input logic [IN_W-1:0] w);
    longint c [NUM_COORDS];
    turn_e  t1;
    turn_e  t2;
    turn_e  t3;
    turn_e  t4;
    for (int i = 0; i < NUM_COORDS; i++) begin
      c[i] = longint'($signed(w[i*COORD_WIDTH +: COORD_WIDTH]));
    end
    // order in c: a start xy, a end xy, b start xy, b end xy
    t1 = orientation(c[0], c[1], c[2], c[3], c[4], c[5]);
    t2 = orientation(c[0], c[1], c[2], c[3], c[6], c[7]);
    t3 = orientation(c[4], c[5], c[6], c[7], c[0], c[1]);
    t4 = orientation(c[4], c[5], c[6], c[7], c[2], c[3]);
    if (t1 != t2 && t3 != t4) return 1'b1;
    if (t1 == TURN_COLLINEAR && within_box(c[0], c[1], c[4], c[5], c[2], c[3])) return 1'b1;
    if (t2 == TURN_COLLINEAR && within_box(c[0], c[1], c[6], c[7], c[2], c[3])) return 1'b1;
    if (t3 == TURN_COLLINEAR && within_box(c[4], c[5], c[0], c[1], c[6], c[7])) return 1'b1;
    if (t4 == TURN_COLLINEAR && within_box(c[4], c[5], c[2], c[3], c[6], c[7])) return 1'b1;
    return 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_hits.delete();
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_hits.size() == 0) begin
          $error("result word with no prediction pending, intersects %0d", m_tdata_i[0]);
          error_count_o <= error_count_o + 1;
        end else begin
          bit hit;
          hit = expected_hits.pop_front();
          if (m_tdata_i[0] !== hit) begin
            $error("intersects mismatch: expected %0d, actual %0d", hit, m_tdata_i[0]);
            error_count_o <= error_count_o + 1;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) expected_hits.push_back(segments_touch(s_tdata_i));
      pending_o <= expected_hits.size();
    end
  end

endmodule

### tb/segment_intersection_test_test.sv
// top of the segment intersection testbench: clock, reset, segment pair stimulus
// with bursty sender and stalling receiver, verdict; checking is done in
// segment_intersection_checker; depends on sit_pkg and the block
`timescale 1ns / 1ps
module segment_intersection_test_test;
  import sit_pkg::*;

  localparam int CW        = 16;
  localparam int IN_W      = ((NUM_COORDS*CW+7)/8)*8;
  localparam int N_RANDOM  = 1600;
  localparam int DRAIN     = 16;
  localparam int MAX_CYCLE = 400000;

  typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_e;

  logic                   clk;
  logic                   rst_n;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_W-1:0]        s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int                     error_count;
  int                     pending;
  int                     cycle_count = 0;
  int                     burst_left;
  bit                     steady;

  segment_intersection_test #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata)
  );

  segment_intersection_checker #(
    .COORD_WIDTH(CW)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLE) begin
      $display("FAILURE");
      $finish;
    end
  end

  // offers one segment pair, opening a new burst when due, outside the steady stretch often after a random gap
  task automatic offer_coords(input int ax0, input int ay0, input int ax1, input int ay1,
                              input int bx0, input int by0, input int bx1, input int by1);
    logic [IN_W-1:0] w;
    w = '0;
    w[0*CW +: CW] = ax0[CW-1:0];
    w[1*CW +: CW] = ay0[CW-1:0];
    w[2*CW +: CW] = ax1[CW-1:0];
    w[3*CW +: CW] = ay1[CW-1:0];
    w[4*CW +: CW] = bx0[CW-1:0];
    w[5*CW +: CW] = by0[CW-1:0];
    w[6*CW +: CW] = bx1[CW-1:0];
    w[7*CW +: CW] = by1[CW-1:0];
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady && $urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  function automatic int full_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 7))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      6: return 32767;
      default: return full_coord();
    endcase
  endfunction

  task automatic offer_random_pair();
    int c [8];
    int px, py, dx, dy, k, j, t;
    int pick;
    pick = $urandom_range(0, 99);
    px = int'($urandom_range(0, 40000)) - 20000;
    py = int'($urandom_range(0, 40000)) - 20000;
    dx = int'($urandom_range(0, 200)) - 100;
    dy = int'($urandom_range(0, 200)) - 100;
    k  = $urandom_range(1, 100);
    j  = $urandom_range(0, k);
    if (pick < 20) begin
      foreach (c[i]) c[i] = full_coord();
    end else if (pick < 45) begin
      foreach (c[i]) c[i] = int'($urandom_range(0, 16)) - 8;
    end else if (pick < 60) begin
      // endpoint of b lying on a, sometimes nudged off by one
      c[0] = px;          c[1] = py;
      c[2] = px + k * dx; c[3] = py + k * dy;
      c[4] = px + j * dx; c[5] = py + j * dy;
      if ($urandom_range(0, 2) == 0) c[4] += ($urandom_range(0, 1) != 0) ? 1 : -1;
      c[6] = c[4] + int'($urandom_range(0, 2000)) - 1000;
      c[7] = c[5] + int'($urandom_range(0, 2000)) - 1000;
    end else if (pick < 72) begin
      // both segments on one line, overlapping or apart
      px = px / 2;
      py = py / 2;
      dx = dx * 2;
      dy = dy * 2;
      for (int i = 0; i < 4; i++) begin
        t = int'($urandom_range(0, 100)) - 50;
        c[2*i]   = px + t * dx;
        c[2*i+1] = py + t * dy;
      end
    end else if (pick < 82) begin
      // a shrunk to a point, on b or next to it
      c[4] = px;          c[5] = py;
      c[6] = px + k * dx; c[7] = py + k * dy;
      c[0] = px + j * dx; c[1] = py + j * dy;
      if ($urandom_range(0, 2) == 0) c[1] += ($urandom_range(0, 1) != 0) ? 1 : -1;
      c[2] = c[0];        c[3] = c[1];
    end else begin
      foreach (c[i]) c[i] = edge_coord();
    end
    if ($urandom_range(0, 1) != 0) begin
      for (int i = 0; i < 4; i++) begin
        t = c[i];
        c[i] = c[i+4];
        c[i+4] = t;
      end
    end
    if ($urandom_range(0, 1) != 0) begin
      t = c[0]; c[0] = c[2]; c[2] = t;
      t = c[1]; c[1] = c[3]; c[3] = t;
    end
    offer_coords(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
  endtask

  initial begin : receiver
    rx_mode_e mode;
    int       phase_count;
    m_tready    = 1'b0;
    phase_count = 0;
    @(posedge rst_n);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      repeat ($urandom_range(50, 300)) begin
        @(negedge clk);
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_HALF:   m_tready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
          default:   m_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
      // long hold-off so the pipeline fills and backs up into the input
      if (phase_count % 4 == 0) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (64) @(negedge clk);
      end
      phase_count++;
    end
  end

  initial begin : stimulus
    burst_left  = 0;
    steady      = 1'b0;
    rst_n       = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // crossing, parallel, collinear overlap, apart and end to end
    offer_coords(-10, -10, 10, 10, -10, 10, 10, -10);
    offer_coords(0, 0, 10, 0, 0, 5, 10, 5);
    offer_coords(0, 0, 10, 0, 5, 0, 15, 0);
    offer_coords(0, 0, 10, 0, 11, 0, 20, 0);
    offer_coords(0, 0, 10, 10, 10, 10, 20, 20);
    offer_coords(0, 0, 2, 2, 3, 3, 5, 5);
    // t junction and its near miss
    offer_coords(0, 0, 10, 0, 5, 0, 5, 8);
    offer_coords(0, 0, 10, 0, 5, 1, 5, 8);
    // point segments
    offer_coords(3, 3, 3, 3, 0, 0, 6, 6);
    offer_coords(3, 4, 3, 4, 0, 0, 6, 6);
    offer_coords(7, -2, 7, -2, 7, -2, 7, -2);
    offer_coords(7, -2, 7, -2, 7, -3, 7, -3);
    // coordinate extremes
    offer_coords(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    offer_coords(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    offer_coords(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    offer_coords(0, 0, 0, 0, 0, 0, 0, 0);
    offer_coords(-32768, -32768, -32768, 0, -32768, 1, -32768, 32767);
    offer_coords(-32768, -32767, 32767, 32767, 0, 1, 0, 32767);
    offer_coords(32767, 32767, -32768, -32768, 32767, 32767, 32767, 32767);
    offer_coords(-32768, 32767, 32767, -32767, -32767, 32767, 32767, -32768);
    offer_coords(10, 10, -10, -10, 10, -10, -10, 10);

    for (int n = 0; n < N_RANDOM; n++) begin
      steady = (n >= 600 && n < 800);
      offer_random_pair();
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/sit_pkg.sv
rtl/sit_diff.sv
rtl/sit_mul.sv
rtl/sit_dec.sv
rtl/segment_intersection_test.sv
tb/segment_intersection_checker.sv
tb/segment_intersection_test_test.sv
